FILE: src/csvfsu_pkg.sv
`timescale 1ns / 1ps

package csvfsu_pkg;

  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned ResDepth = 4;
  localparam int unsigned PtrW     = $clog2(ResDepth);
  localparam int unsigned CntW     = $clog2(ResDepth + 1);

  localparam logic [CfgIdxW-1:0] RegDelimiter = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegQuote     = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegEscape    = CfgIdxW'(2);

  localparam logic [7:0] DelimiterReset = 8'd44;
  localparam logic [7:0] QuoteReset     = 8'd34;
  localparam logic [7:0] EscapeReset    = 8'd92;

  typedef enum logic [1:0] {
    ModeStart  = 2'd0,
    ModePlain  = 2'd1,
    ModeQuoted = 2'd2,
    ModeSkip   = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e      mode;
    logic [7:0] held;
    logic       held_valid;
    logic       esc_done;
    logic       row_term;
  } state_t;

  typedef struct packed {
    logic [7:0] delimiter;
    logic [7:0] quote;
    logic [7:0] escape;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       row_end;
  } item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       vld;
    logic       field_end;
    logic       row_done;
    logic       last;
  } res_t;

  typedef struct packed {
    res_t       r0;
    res_t       r1;
    logic [1:0] num;
  } res_pair_t;

  typedef struct packed {
    state_t st;
    logic   used;
    logic   emit;
    res_t   r;
  } dec_t;

  typedef struct packed {
    state_t st;
    res_t   r;
  } fin_t;

  typedef struct packed {
    state_t    st;
    res_pair_t res;
  } step_t;

  function automatic logic is_open(input mode_e m);
    return (m == ModePlain) || (m == ModeQuoted);
  endfunction

  function automatic state_t take_byte(input state_t s, input cfg_t c, input logic [7:0] b);
    state_t o;
    o = s;
    case (s.mode)
      ModeStart: begin
        if (b == c.quote) begin
          o.mode = ModeQuoted;
        end else begin
          o.mode       = ModePlain;
          o.held       = b;
          o.held_valid = 1'b1;
          o.esc_done   = 1'b0;
        end
      end
      ModePlain, ModeQuoted: begin
        o.held       = b;
        o.held_valid = 1'b1;
        o.esc_done   = 1'b0;
      end
      default: begin
        if (b == c.delimiter) begin
          o.mode = ModeStart;
        end
      end
    endcase
    return o;
  endfunction

  function automatic dec_t decide(input state_t s, input cfg_t c, input logic has_next,
                                  input logic [7:0] nxt);
    dec_t       o;
    logic       dq;
    logic       brk;
    o              = '0;
    o.st           = s;
    o.st.held_valid = 1'b0;
    dq             = 1'b0;
    brk            = 1'b0;
    if (!s.esc_done && (s.held == c.escape) && has_next) begin
      o.st.held       = nxt;
      o.st.held_valid = 1'b1;
      o.st.esc_done   = 1'b1;
      o.used          = 1'b1;
    end else begin
      o.st.esc_done = 1'b0;
      dq = (s.held == c.quote) && has_next && (nxt == c.quote);
      if ((s.mode == ModeQuoted) && !dq) begin
        brk = (s.held == c.quote);
      end else begin
        brk = (s.held == c.delimiter);
      end
      o.emit = 1'b1;
      o.used = dq;
      if (brk) begin
        o.r.field_end = 1'b1;
        o.st.mode     = (s.mode == ModeQuoted) ? ModeSkip : ModeStart;
      end else begin
        o.r.data = s.held;
        o.r.vld  = 1'b1;
      end
    end
    return o;
  endfunction

  function automatic fin_t finish(input state_t s, input cfg_t c);
    fin_t o;
    dec_t d;
    o = '0;
    d = decide(s, c, 1'b0, 8'd0);
    if (is_open(s.mode) && s.held_valid) begin
      o.r           = d.r;
      o.r.field_end = 1'b1;
      o.r.row_done  = 1'b1;
    end else if (is_open(s.mode)) begin
      o.r.field_end = 1'b1;
      o.r.row_done  = 1'b1;
    end else begin
      o.r.row_done = 1'b1;
    end
    o.st            = s;
    o.st.mode       = ModeStart;
    o.st.held       = 8'd0;
    o.st.held_valid = 1'b0;
    o.st.esc_done   = 1'b0;
    return o;
  endfunction

  function automatic step_t step(input state_t s, input cfg_t c, input item_t it);
    step_t  o;
    dec_t   d;
    fin_t   f;
    state_t t;
    o    = '0;
    o.st = s;
    t    = s;
    if (s.row_term) begin
      o.st.row_term = !it.row_end;
    end else if (it.present && (it.data == 8'd0)) begin
      f             = finish(s, c);
      o.res.r0      = f.r;
      o.res.num     = 2'd1;
      o.st          = f.st;
      o.st.row_term = !it.row_end;
    end else begin
      if (it.present) begin
        if (is_open(t.mode) && t.held_valid) begin
          d = decide(t, c, 1'b1, it.data);
          t = d.st;
          if (!d.used) begin
            t = take_byte(t, c, it.data);
          end
          if (d.emit) begin
            o.res.r0  = d.r;
            o.res.num = 2'd1;
          end
        end else begin
          t = take_byte(t, c, it.data);
        end
      end
      if (it.row_end) begin
        f = finish(t, c);
        t = f.st;
        if (o.res.num == 2'd1) begin
          o.res.r1  = f.r;
          o.res.num = 2'd2;
        end else begin
          o.res.r0  = f.r;
          o.res.num = 2'd1;
        end
      end
      o.st = t;
    end
    if (o.res.num == 2'd2) begin
      o.res.r1.last = 1'b1;
    end else if (o.res.num == 2'd1) begin
      o.res.r0.last = 1'b1;
    end
    return o;
  endfunction

endpackage

FILE: src/csvfsu_if.sv
`timescale 1ns / 1ps

interface csvfsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       byte_present;
  logic       row_end;

  modport source (output valid, in_byte, byte_present, row_end, input ready);
  modport sink (input valid, in_byte, byte_present, row_end, output ready);
endinterface

interface csvfsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       field_end;
  logic       row_done;
  logic       last;

  modport source (output valid, out_byte, out_valid, field_end, row_done, last, input ready);
  modport sink (input valid, out_byte, out_valid, field_end, row_done, last, output ready);
endinterface

interface csvfsu_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [csvfsu_pkg::CfgIdxW-1:0]   index;
  logic [7:0]                       data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: src/csvfsu_parse.sv
`timescale 1ns / 1ps

module csvfsu_parse (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  csvfsu_pkg::item_t     item_i,
  input  csvfsu_pkg::cfg_t      cfg_i,
  input  logic                  room_i,
  output csvfsu_pkg::res_pair_t res_o
);

  logic                 vld_q;
  csvfsu_pkg::item_t    item_q;
  csvfsu_pkg::state_t   state_q;
  csvfsu_pkg::state_t   state_d;
  csvfsu_pkg::step_t    stp;
  logic                 adv;

  assign adv        = vld_q && room_i;
  assign in_ready_o = !vld_q || adv;

  always_comb begin
    stp     = csvfsu_pkg::step(state_q, cfg_i, item_q);
    state_d = stp.st;
    res_o   = stp.res;
    if (!adv) begin
      res_o.num = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= 1'b0;
      state_q <= '{mode: csvfsu_pkg::ModeStart, held: 8'd0, held_valid: 1'b0,
                   esc_done: 1'b0, row_term: 1'b0};
    end else begin
      if (in_ready_o) begin
        vld_q <= in_valid_i;
      end
      if (adv) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

endmodule

FILE: src/csvfsu_res_fifo.sv
`timescale 1ns / 1ps

module csvfsu_res_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  csvfsu_pkg::res_pair_t push_i,
  output logic                  room_o,
  output logic                  valid_o,
  input  logic                  ready_i,
  output csvfsu_pkg::res_t      head_o
);

  csvfsu_pkg::res_t                    mem_q [csvfsu_pkg::ResDepth];
  logic [csvfsu_pkg::PtrW-1:0]         wr_q;
  logic [csvfsu_pkg::PtrW-1:0]         rd_q;
  logic [csvfsu_pkg::CntW-1:0]         cnt_q;
  logic [csvfsu_pkg::CntW-1:0]         cnt_d;
  logic                                pop;

  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign pop     = valid_o && ready_i;
  assign room_o  = (cnt_q <= csvfsu_pkg::CntW'(csvfsu_pkg::ResDepth - 2));
  assign cnt_d   = cnt_q + csvfsu_pkg::CntW'(push_i.num) - csvfsu_pkg::CntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + csvfsu_pkg::PtrW'(push_i.num);
      rd_q  <= rd_q + csvfsu_pkg::PtrW'(pop);
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_q + csvfsu_pkg::PtrW'(1)] <= push_i.r1;
    end
  end

endmodule

FILE: src/csv_field_splitter_unescaper.sv
`timescale 1ns / 1ps
// CSV field splitter and unescaper.
// in_s carries the bytes of a row (in_byte, byte_present, row_end); out_s
// delivers unescaped field bytes with field_end, row_done and last marks;
// cfg_s writes delimiter (index 0), quote (index 1) and escape (index 2).
// cfg_s is always ready; write it only while no item is in flight.
// Each accepted item is registered, decided against one byte of lookahead
// once the result queue has room, and its zero to two results enter a
// four-entry result queue whose head drives out_s. With an empty queue the
// first result of an item passes the item register and the queue storage
// before it is offered on out_s.
// Throughput: one item per cycle while items give at most one result each
// and the sink takes every result; an item with two results needs two
// output transfers. The single output port of the queue sets the rate.
// in_s.ready falls when an item waits and the queue has under two free
// entries, so a stalled sink fills at most four results before input stops.
// Reset clears the queue, the lookahead and the field state, and loads
// comma, double quote and backslash into the registers.
module csv_field_splitter_unescaper (
  input logic          clk_i,
  input logic          rst_ni,
  csvfsu_in_if.sink    in_s,
  csvfsu_out_if.source out_s,
  csvfsu_cfg_if.sink   cfg_s
);

  csvfsu_pkg::cfg_t      cfg_q;
  csvfsu_pkg::item_t     item;
  csvfsu_pkg::res_pair_t pair;
  csvfsu_pkg::res_t      head;
  logic                  room;

  assign cfg_s.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{delimiter: csvfsu_pkg::DelimiterReset, quote: csvfsu_pkg::QuoteReset,
                 escape: csvfsu_pkg::EscapeReset};
    end else if (cfg_s.valid && cfg_s.ready) begin
      case (cfg_s.index)
        csvfsu_pkg::RegDelimiter: cfg_q.delimiter <= cfg_s.data;
        csvfsu_pkg::RegQuote:     cfg_q.quote     <= cfg_s.data;
        csvfsu_pkg::RegEscape:    cfg_q.escape    <= cfg_s.data;
        default: ;
      endcase
    end
  end

  assign item = '{data: in_s.in_byte, present: in_s.byte_present, row_end: in_s.row_end};

  csvfsu_parse u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_s.valid),
    .in_ready_o (in_s.ready),
    .item_i     (item),
    .cfg_i      (cfg_q),
    .room_i     (room),
    .res_o      (pair)
  );

  csvfsu_res_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (pair),
    .room_o  (room),
    .valid_o (out_s.valid),
    .ready_i (out_s.ready),
    .head_o  (head)
  );

  assign out_s.out_byte  = head.data;
  assign out_s.out_valid = head.vld;
  assign out_s.field_end = head.field_end;
  assign out_s.row_done  = head.row_done;
  assign out_s.last      = head.last;

endmodule

FILE: src/csvfsu_checker.sv
`timescale 1ns / 1ps

module csvfsu_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cfg_ready_i,
  input logic       out_vld_i,
  input logic       out_rdy_i,
  input logic [7:0] out_byte_i,
  input logic       out_valid_i,
  input logic       field_end_i,
  input logic       row_done_i,
  input logic       last_i
);

  // hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_i && !out_rdy_i |=> out_vld_i &&
      $stable({out_byte_i, out_valid_i, field_end_i, row_done_i, last_i}))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_i && row_done_i |-> last_i)
    else $error("row end not on last result of its item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_i && row_done_i && !field_end_i |-> !out_valid_i)
    else $error("row end outside a field carries a byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_i && !out_valid_i |-> (out_byte_i == 8'd0) && (field_end_i || row_done_i))
    else $error("empty result without a mark");

  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_i)
    else $error("configuration port not ready");

endmodule

bind csv_field_splitter_unescaper csvfsu_checker u_csvfsu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_ready_i (cfg_s.ready),
  .out_vld_i   (out_s.valid),
  .out_rdy_i   (out_s.ready),
  .out_byte_i  (out_s.out_byte),
  .out_valid_i (out_s.out_valid),
  .field_end_i (out_s.field_end),
  .row_done_i  (out_s.row_done),
  .last_i      (out_s.last)
);
